FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PDD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pdd assertion failed");

// checked at every edge, reset included
`define PDD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("pdd assertion failed");

`endif

FILE: hdl/pdd_pkg.sv
package pdd_pkg;

  typedef enum logic [1:0] {
    CASE_ABLATION = 2'd0,
    CASE_NO_MELT  = 2'd1,
    CASE_PARTIAL  = 2'd2,
    CASE_ALL_MELT = 2'd3
  } case_e;

  localparam logic [16:0] RF_RESET = 17'd39322;
  localparam logic [16:0] RF_ONE   = 17'd65536;
  localparam int ICE_NW  = 71;
  localparam int RATE_NW = 57;

  localparam logic signed [58:0] RATE_MAX = 59'sd140737488355327;
  localparam logic signed [58:0] RATE_MIN = -59'sd140737488355328;

  typedef struct packed {
    case_e              code;
    logic signed [47:0] acc;
    logic signed [56:0] ps;
    logic signed [56:0] pi;
    logic signed [49:0] ar;
    logic [24:0]        dt;
  } ice_side_t;

  typedef struct packed {
    case_e code;
    logic  neg;
  } rate_side_t;

  function automatic logic [47:0] sat48(input logic signed [58:0] v);
    logic signed [58:0] r;
    r = v;
    if (v > RATE_MAX) r = RATE_MAX;
    if (v < RATE_MIN) r = RATE_MIN;
    return r[47:0];
  endfunction

endpackage

FILE: hdl/pdd_div.sv
module pdd_div #(
  parameter int NW = 8,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [NW-1:0] work_q [NW];
  logic [DW-1:0] rem_q  [NW-1];
  logic [DW-1:0] den_q  [NW-1];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic [NW-1:0] w_in;
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [DW:0]   trial;
    logic          ge;
    if (k == 0) begin : g_first
      assign w_in = num_i;
      assign r_in = '0;
      assign d_in = den_i;
    end else begin : g_next
      assign w_in = work_q[k-1];
      assign r_in = rem_q[k-1];
      assign d_in = den_q[k-1];
    end
    assign trial = {r_in, w_in[NW-1]};
    assign ge    = trial >= {1'b0, d_in};
    always_ff @(posedge clk_i) begin
      work_q[k] <= {w_in[NW-2:0], ge};
    end
    if (k < NW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[k] <= ge ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
        den_q[k] <= d_in;
      end
    end
  end

  assign quo_o = work_q[NW-1];

endmodule

FILE: hdl/pdd_melt_mass_flux_unit.sv
// channel   | handshake               | payload
// input     | start_i, busy_o         | degree_day_sum_i .. ice_melt_factor_i
// config    | cfg_valid_i, cfg_ready_o| cfg_data_i
// result    | done_o (one cycle)      | *_rate_out_o, case_code_o
// one transaction enters per cycle; done_o rises after these registered stages, in order:
// capture, products, case select, a 71-stage restoring divider for the ice melt,
// the dividend stage, 57-stage dividers for the rates and the output register.
// busy_o and cfg_ready_o stay low and high; the pipeline never stalls.
// reset clears the valid bits and sets the refreeze register to 39322.
module pdd_melt_mass_flux_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] degree_day_sum_i,
  input  logic signed [31:0] accumulation_amount_i,
  input  logic [24:0]        step_seconds_i,
  input  logic [23:0]        snow_melt_factor_i,
  input  logic [23:0]        ice_melt_factor_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [16:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [47:0] accumulation_rate_out_o,
  output logic signed [47:0] melt_rate_out_o,
  output logic signed [47:0] runoff_rate_out_o,
  output logic signed [47:0] balance_rate_out_o,
  output logic [1:0]         case_code_o
);
  import pdd_pkg::*;

  logic [16:0] rf_q;
  logic [16:0] rf_eff;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_q <= RF_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rf_q <= cfg_data_i;
    end
  end

  assign rf_eff = (rf_q > RF_ONE) ? RF_ONE : rf_q;

  // stage 0: capture
  logic               v0_q;
  logic signed [31:0] p0_q, a0_q;
  logic [24:0]        dt0_q;
  logic [23:0]        s0_q, i0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= start_i && !busy_o;
  end

  always_ff @(posedge clk_i) begin
    p0_q  <= degree_day_sum_i;
    a0_q  <= accumulation_amount_i;
    dt0_q <= (step_seconds_i == '0) ? 25'd1 : step_seconds_i;
    s0_q  <= snow_melt_factor_i;
    i0_q  <= ice_melt_factor_i;
  end

  // stage 1: products
  logic               v1_q;
  logic signed [56:0] ps1_q, pi1_q, ai1_q;
  logic signed [49:0] ar1_q;
  logic signed [31:0] a1_q;
  logic               ppos1_q;
  logic [23:0]        s1_q;
  logic [24:0]        dt1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    ps1_q   <= 57'(p0_q * $signed({1'b0, s0_q}));
    pi1_q   <= 57'(p0_q * $signed({1'b0, i0_q}));
    ai1_q   <= 57'(a0_q * $signed({1'b0, i0_q}));
    ar1_q   <= 50'(a0_q * $signed({1'b0, rf_eff}));
    a1_q    <= a0_q;
    ppos1_q <= p0_q > 32'sd0;
    s1_q    <= s0_q;
    dt1_q   <= dt0_q;
  end

  // stage 2: case select and ice dividend
  logic signed [47:0] acc1;
  case_e              code1;
  logic               v2_q;
  logic [ICE_NW-1:0]  num2_q;
  logic [23:0]        s2_q;
  ice_side_t          side2_q;

  assign acc1 = {a1_q, 16'b0};

  always_comb begin
    priority if (a1_q < 32'sd0)            code1 = CASE_ABLATION;
    else if (!ppos1_q)                     code1 = CASE_NO_MELT;
    else if (ps1_q <= 57'(acc1))           code1 = CASE_PARTIAL;
    else                                   code1 = CASE_ALL_MELT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    num2_q       <= ICE_NW'({ai1_q[54:0], 16'b0}) + ICE_NW'(s1_q) - ICE_NW'(1);
    s2_q         <= s1_q;
    side2_q.code <= code1;
    side2_q.acc  <= acc1;
    side2_q.ps   <= ps1_q;
    side2_q.pi   <= pi1_q;
    side2_q.ar   <= ar1_q;
    side2_q.dt   <= dt1_q;
  end

  // ceil(acc * ice_factor / snow_factor)
  logic [ICE_NW-1:0] ice_quo;

  pdd_div #(.NW(ICE_NW), .DW(24)) u_ice_div (
    .clk_i (clk_i),
    .num_i (num2_q),
    .den_i (s2_q),
    .quo_o (ice_quo)
  );

  ice_side_t         isd_q [ICE_NW];
  logic [ICE_NW-1:0] iv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) iv_q <= '0;
    else         iv_q <= {iv_q[ICE_NW-2:0], v2_q};
  end

  always_ff @(posedge clk_i) begin
    isd_q[0] <= side2_q;
    for (int k = 1; k < ICE_NW; k++) isd_q[k] <= isd_q[k-1];
  end

  // stage 4: rate dividends
  ice_side_t          is4;
  logic signed [56:0] ice_s;
  logic [55:0]        ice_u;
  logic [47:0]        acc_u;
  logic               neg4;
  logic [RATE_NW-1:0] n2_d, n3_d;

  assign is4   = isd_q[ICE_NW-1];
  assign ice_s = is4.pi - $signed({1'b0, ice_quo[55:0]});
  assign ice_u = ice_s[55:0];
  assign neg4  = is4.code == CASE_ABLATION;
  assign acc_u = neg4 ? 48'(-is4.acc) : 48'(is4.acc);

  always_comb begin
    unique case (is4.code)
      CASE_PARTIAL: begin
        n2_d = RATE_NW'(is4.ps[55:0]);
        n3_d = '0;
      end
      CASE_ALL_MELT: begin
        n2_d = RATE_NW'(acc_u) + RATE_NW'(ice_u);
        n3_d = RATE_NW'(acc_u) - RATE_NW'(is4.ar[47:0]) + RATE_NW'(ice_u);
      end
      default: begin
        n2_d = '0;
        n3_d = '0;
      end
    endcase
  end

  logic               v4_q;
  logic [RATE_NW-1:0] n1_q, n2_q, n3_q;
  logic [24:0]        dt4_q;
  rate_side_t         rs4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= iv_q[ICE_NW-1];
  end

  always_ff @(posedge clk_i) begin
    n1_q       <= RATE_NW'(acc_u);
    n2_q       <= n2_d;
    n3_q       <= n3_d;
    dt4_q      <= is4.dt;
    rs4_q.code <= is4.code;
    rs4_q.neg  <= neg4;
  end

  logic [RATE_NW-1:0] q1, q2, q3;

  pdd_div #(.NW(RATE_NW), .DW(25)) u_acc_div (
    .clk_i (clk_i),
    .num_i (n1_q),
    .den_i (dt4_q),
    .quo_o (q1)
  );

  pdd_div #(.NW(RATE_NW), .DW(25)) u_melt_div (
    .clk_i (clk_i),
    .num_i (n2_q),
    .den_i (dt4_q),
    .quo_o (q2)
  );

  pdd_div #(.NW(RATE_NW), .DW(25)) u_runoff_div (
    .clk_i (clk_i),
    .num_i (n3_q),
    .den_i (dt4_q),
    .quo_o (q3)
  );

  rate_side_t         rsd_q [RATE_NW];
  logic [RATE_NW-1:0] rv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= '0;
    else         rv_q <= {rv_q[RATE_NW-2:0], v4_q};
  end

  always_ff @(posedge clk_i) begin
    rsd_q[0] <= rs4_q;
    for (int k = 1; k < RATE_NW; k++) rsd_q[k] <= rsd_q[k-1];
  end

  // stage 5: sign, select, saturate
  rate_side_t         rs5;
  logic signed [58:0] q1s, q2s, q3s;
  logic signed [58:0] accr, melt, runoff, smb;

  assign rs5 = rsd_q[RATE_NW-1];
  assign q1s = rs5.neg ? -$signed({2'b0, q1}) : $signed({2'b0, q1});
  assign q2s = $signed({2'b0, q2});
  assign q3s = $signed({2'b0, q3});

  always_comb begin
    unique case (rs5.code)
      CASE_ABLATION: begin
        accr = '0; melt = q1s; runoff = q1s; smb = q1s;
      end
      CASE_NO_MELT: begin
        accr = q1s; melt = '0; runoff = '0; smb = q1s;
      end
      CASE_PARTIAL: begin
        accr = q1s; melt = q2s; runoff = '0; smb = q1s;
      end
      CASE_ALL_MELT: begin
        accr = q1s; melt = q2s; runoff = q3s; smb = q1s - q3s;
      end
      default: begin
        accr = '0; melt = '0; runoff = '0; smb = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= rv_q[RATE_NW-1];
  end

  always_ff @(posedge clk_i) begin
    accumulation_rate_out_o <= sat48(accr);
    melt_rate_out_o         <= sat48(melt);
    runoff_rate_out_o       <= sat48(runoff);
    balance_rate_out_o      <= sat48(smb);
    case_code_o             <= rs5.code;
  end

endmodule

FILE: hdl/pdd_chk.sv
`include "assert_macros.svh"

module pdd_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               busy_o,
  input logic               cfg_ready_o,
  input logic               done_o,
  input logic signed [47:0] accumulation_rate_out_o,
  input logic signed [47:0] melt_rate_out_o,
  input logic signed [47:0] runoff_rate_out_o,
  input logic [1:0]         case_code_o
);
  import pdd_pkg::*;

  `PDD_ASSERT_ALWAYS(a_no_done_in_reset, clk_i, !rst_ni |-> !done_o)
  `PDD_ASSERT(a_always_ready, clk_i, rst_ni, !busy_o && cfg_ready_o)
  `PDD_ASSERT(a_ablation_acc, clk_i, rst_ni, (done_o && case_code_o == CASE_ABLATION) |-> (accumulation_rate_out_o == '0 && melt_rate_out_o == runoff_rate_out_o))
  `PDD_ASSERT(a_no_melt_zero, clk_i, rst_ni, (done_o && case_code_o == CASE_NO_MELT) |-> (melt_rate_out_o == '0 && runoff_rate_out_o == '0))

endmodule

bind pdd_melt_mass_flux_unit pdd_chk u_pdd_chk (.*);

FILE: verif/tb_pdd_melt_mass_flux_unit.sv
`timescale 1ns / 100ps

module tb_pdd_melt_mass_flux_unit;
  import pdd_pkg::*;

  localparam int LATENCY = 133;
  localparam longint CYCLE_LIMIT = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [31:0] degree_day_sum_i = '0;
  logic signed [31:0] accumulation_amount_i = '0;
  logic [24:0]        step_seconds_i = 25'd1;
  logic [23:0]        snow_melt_factor_i = 24'd1;
  logic [23:0]        ice_melt_factor_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [16:0]        cfg_data_i = '0;
  logic               done_o;
  logic signed [47:0] accumulation_rate_out_o;
  logic signed [47:0] melt_rate_out_o;
  logic signed [47:0] runoff_rate_out_o;
  logic signed [47:0] balance_rate_out_o;
  logic [1:0]         case_code_o;

  typedef struct {
    logic signed [47:0] exp_accum;
    logic signed [47:0] exp_melt;
    logic signed [47:0] exp_runoff;
    logic signed [47:0] exp_balance;
    case_e              code;
  } flux_t;

  flux_t       flux_q[$];
  logic [16:0] refreeze_frac = RF_RESET;
  int          n_errors = 0;
  int          n_items = 0;
  int          n_results = 0;
  int          n_cases[4] = '{0, 0, 0, 0};
  longint      n_cycles = 0;

  pdd_melt_mass_flux_unit i_dut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("pdd_melt_mass_flux_unit test failed");
      $finish;
    end
  end

  function automatic logic signed [47:0] clamp48(input logic signed [127:0] v);
    if (v > 128'sd140737488355327) return 48'sh7fffffffffff;
    if (v < -128'sd140737488355328) return 48'sh800000000000;
    return v[47:0];
  endfunction

  function automatic flux_t melt_flux(input logic signed [31:0] pdd,
                                      input logic signed [31:0] accum,
                                      input logic [24:0] step,
                                      input logic [23:0] snow_f,
                                      input logic [23:0] ice_f,
                                      input logic [16:0] rfz);
    flux_t f;
    logic signed [127:0] p, a, dt, s, fi, r, acc, accr, melt, runoff, smb;
    logic signed [127:0] ice, d;
    p = pdd;
    a = accum;
    dt = (step == 0) ? 128'sd1 : $signed({103'd0, step});
    s = $signed({104'd0, snow_f});
    fi = $signed({104'd0, ice_f});
    r = (rfz > RF_ONE) ? 128'sd65536 : $signed({111'd0, rfz});
    acc = a * 65536;
    if (a < 0) begin
      accr = 0;
      melt = acc / dt;
      runoff = melt;
      smb = melt;
      f.code = CASE_ABLATION;
    end else begin
      accr = acc / dt;
      if (p <= 0) begin
        melt = 0;
        runoff = 0;
        smb = accr;
        f.code = CASE_NO_MELT;
      end else if (p * s <= acc) begin
        melt = (p * s) / dt;
        runoff = 0;
        smb = accr;
        f.code = CASE_PARTIAL;
      end else begin
        ice = 0;
        if (s != 0) begin
          d = p * s - acc;
          ice = (d / s) * fi + ((d % s) * fi) / s;
        end
        melt = (acc + ice) / dt;
        runoff = (acc - a * r + ice) / dt;
        smb = accr - runoff;
        f.code = CASE_ALL_MELT;
      end
    end
    f.exp_accum = clamp48(accr);
    f.exp_melt = clamp48(melt);
    f.exp_runoff = clamp48(runoff);
    f.exp_balance = clamp48(smb);
    return f;
  endfunction

  always @(posedge clk_i) begin
    flux_t e;
    if (rst_ni && done_o) begin
      n_results++;
      if (flux_q.size() == 0) begin
        $error("result with no expected transaction");
        n_errors++;
      end else begin
        e = flux_q.pop_front();
        n_cases[e.code]++;
        if (accumulation_rate_out_o !== e.exp_accum) begin
          $error("accumulation_rate_out exp %0d got %0d", e.exp_accum,
                 accumulation_rate_out_o);
          n_errors++;
        end
        if (melt_rate_out_o !== e.exp_melt) begin
          $error("melt_rate_out exp %0d got %0d", e.exp_melt, melt_rate_out_o);
          n_errors++;
        end
        if (runoff_rate_out_o !== e.exp_runoff) begin
          $error("runoff_rate_out exp %0d got %0d", e.exp_runoff, runoff_rate_out_o);
          n_errors++;
        end
        if (balance_rate_out_o !== e.exp_balance) begin
          $error("balance_rate_out exp %0d got %0d", e.exp_balance,
                 balance_rate_out_o);
          n_errors++;
        end
        if (case_code_o !== e.code) begin
          $error("case_code exp %0d got %0d", e.code, case_code_o);
          n_errors++;
        end
      end
    end
  end

  task automatic send_cell(input logic signed [31:0] pdd, input logic signed [31:0] accum,
                           input logic [24:0] step, input logic [23:0] snow_f,
                           input logic [23:0] ice_f, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    degree_day_sum_i <= pdd;
    accumulation_amount_i <= accum;
    step_seconds_i <= step;
    snow_melt_factor_i <= snow_f;
    ice_melt_factor_i <= ice_f;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    flux_q.push_back(melt_flux(pdd, accum, step, snow_f, ice_f, refreeze_frac));
    n_items++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (flux_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_refreeze(input logic [16:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    refreeze_frac = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_cell(32'sh7fffffff, 32'sh7fffffff, 25'h1ffffff, 24'hffffff, 24'hffffff, 0);
    send_cell(32'sh80000000, 32'sh80000000, 25'd1, 24'd1, 24'd0, 0);
    send_cell(32'sh80000000, 32'sh7fffffff, 25'd1, 24'hffffff, 24'hffffff, 0);
    send_cell(32'sh7fffffff, 32'sh80000000, 25'd0, 24'hffffff, 24'd0, 0);
    send_cell(32'sd0, 32'sd0, 25'd1, 24'd1, 24'd0, 0);
    send_cell(32'sd0, 32'sd100, 25'd3, 24'd7, 24'd9, 0);
    send_cell(32'sd65536, 32'sd16777216, 25'd86400, 24'd50000, 24'd80000, 0);
    send_cell(32'sd1, 32'sd1, 25'd1, 24'd65536, 24'd1, 0);
    send_cell(32'sd65536, 32'sd0, 25'd1, 24'd1, 24'hffffff, 0);
    send_cell(32'sh7fffffff, 32'sd0, 25'd1, 24'hffffff, 24'hffffff, 0);
    send_cell(32'sh7fffffff, 32'sd1, 25'd0, 24'hffffff, 24'hffffff, 0);
    send_cell(32'sd1000, 32'sd1000, 25'd7, 24'd0, 24'd5, 0);
    send_cell(32'sd300, 32'sd1, 25'd2, 24'd218, 24'hffffff, 0);
    send_cell(-32'sd5, 32'sh7fffffff, 25'h1ffffff, 24'd1, 24'd1, 0);
    send_cell(32'sd123456, -32'sd1, 25'd1, 24'd999, 24'd999, 0);
    drain();
  endtask

  task automatic random_cell(input bit gaps);
    logic signed [31:0] p, a;
    logic [24:0] dt;
    logic [23:0] s, fi;
    p = $urandom;
    a = $urandom;
    dt = 25'($urandom);
    s = 24'($urandom);
    fi = 24'($urandom);
    case ($urandom_range(0, 5))
      0: begin
        p = $urandom_range(0, 32'h000fffff);
        a = $urandom_range(0, 32'h00ffffff);
        dt = 25'($urandom_range(1, 100000));
      end
      1: a = a & 32'h7fffffff;
      2: begin
        p = $urandom_range(1, 32'h0fffffff);
        a = $urandom_range(0, 32'h0000ffff);
        s = 24'($urandom_range(1, 24'hffff));
      end
      3: dt = 25'($urandom_range(0, 3));
      default: ;
    endcase
    if (s == 0 && $urandom_range(0, 3) != 0) s = 1;
    send_cell(p, a, dt, s, fi, gaps);
  endtask

  task automatic test_random(input int count, input bit gaps);
    repeat (count) random_cell(gaps && ($urandom_range(0, 3) != 0));
    drain();
  endtask

  task automatic test_refreeze_settings();
    logic [16:0] vals[5] = '{17'd0, RF_ONE, 17'h1ffff, 17'd12345, RF_RESET};
    foreach (vals[k]) begin
      write_refreeze(vals[k]);
      send_cell(32'sh7fffffff, 32'sd1000000, 25'd1, 24'd4096, 24'd8192, 0);
      send_cell(32'sd655360, 32'sd16777216, 25'd10, 24'd300000, 24'd600000, 0);
      test_random(60, 1);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(200, 0);
    test_random(200, 1);
    test_refreeze_settings();
    $display("cells sent: %0d, results checked: %0d", n_items, n_results);
    $display("cases ablation/no melt/partial/all melt: %0d/%0d/%0d/%0d",
             n_cases[0], n_cases[1], n_cases[2], n_cases[3]);
    if (n_errors == 0 && flux_q.size() == 0) begin
      $display("pdd_melt_mass_flux_unit test passed");
    end else begin
      $display("pdd_melt_mass_flux_unit test failed");
    end
    $finish;
  end

endmodule
